FILE: rtl/core/foe_pkg.sv
// Shared types, constants and the root table of the force offset estimator.
package foe_pkg;

  localparam int MAG_W      = 64;
  localparam int DIG_W      = 16;
  localparam int NUM_DIG    = MAG_W / DIG_W;
  localparam int ACC_W      = 2 * MAG_W;
  localparam int CNT_W      = $clog2(NUM_DIG + 1);
  localparam int SH_W       = 6;
  localparam int COUNT_W    = 32;
  localparam int LOG_INT_W  = 5;
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
  localparam int EXP_W      = 33;
  localparam int STEP_W     = 17;
  localparam int ITER_W     = 5;
  localparam int ROOT_W     = 32;
  localparam int ROOT_N     = 16;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_OUT_W = 20;
  localparam int OFS_OUT_W  = 25;

  localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(1) << 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY = 1'b0,
    CFG_PAUSE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_ISSUE,
    ST_WAIT,
    ST_EXP_SEL,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_SQR,
    OP_RATE,
    OP_EXP,
    OP_ERR_X,
    OP_ERR_Y,
    OP_DELTA,
    OP_GAIN_X,
    OP_GAIN_Y
  } op_t;

  typedef struct packed {
    logic             start;
    logic [SH_W-1:0]  shift;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } mul_req_t;

  typedef logic [ROOT_W-1:0] root_rom_t [ROOT_N];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] acc;
    logic [63:0] bt;
    v   = v_in;
    acc = '0;
    bt  = 64'h1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 64'h0) begin
      if (v >= acc + bt) begin
        v   = v - (acc + bt);
        acc = (acc >> 1) + bt;
      end else begin
        acc = acc >> 1;
      end
      bt = bt >> 2;
    end
    return acc;
  endfunction

  function automatic root_rom_t build_roots();
    root_rom_t   rom;
    logic [63:0] r;
    r      = 64'h8000_0000;
    rom[0] = r[ROOT_W-1:0];
    for (int i = 1; i < ROOT_N; i++) begin
      r      = isqrt64(r << 32);
      rom[i] = r[ROOT_W-1:0];
    end
    return rom;
  endfunction

  localparam root_rom_t ROOT_ROM = build_roots();

endpackage

FILE: rtl/core/foe_ifs.sv
// Channel interfaces for samples, results and register writes.
interface foe_sample_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] force_z;
  logic signed [DATA_WIDTH-1:0] torque_x;
  logic signed [DATA_WIDTH-1:0] torque_y;
  modport source(output valid, force_z, torque_x, torque_y, input ready);
  modport sink(input valid, force_z, torque_x, torque_y, output ready);
endinterface

interface foe_result_if import foe_pkg::*; ;
  logic                         valid;
  logic                         ready;
  logic signed [GAIN_OUT_W-1:0] gain_x;
  logic signed [GAIN_OUT_W-1:0] gain_y;
  logic [OFS_OUT_W-1:0]         force_offset;
  logic [COUNT_W-1:0]           samples_seen;
  modport source(output valid, gain_x, gain_y, force_offset, samples_seen, input ready);
  modport sink(input valid, gain_x, gain_y, force_offset, samples_seen, output ready);
endinterface

interface foe_cfg_if import foe_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/foe_mul.sv
// Shared digit-serial magnitude multiplier with right shift and saturation.
module foe_mul import foe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mul_req_t         req,
  output logic             done,
  output logic [MAG_W-1:0] res
);

  logic [MAG_W-1:0]       a_q;
  logic [MAG_W-1:0]       b_q;
  logic [ACC_W-1:0]       acc;
  logic [SH_W-1:0]        sh_q;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   round;
  logic [MAG_W+DIG_W-1:0] part;
  logic [ACC_W-1:0]       shifted;
  logic [MAG_W-1:0]       capped;

  assign part    = a_q * b_q[MAG_W-1 -: DIG_W];
  assign shifted = acc >> sh_q;

  always_comb begin
    if (|acc[ACC_W-1:MAG_W]) begin
      capped = MAG_CAP;
    end else if (shifted[MAG_W-1:0] > MAG_CAP) begin
      capped = MAG_CAP;
    end else begin
      capped = shifted[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_DIG);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy  <= 1'b0;
          round <= 1'b1;
        end
      end
      if (round) begin
        round <= 1'b0;
        done  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q  <= req.a;
      b_q  <= req.b;
      sh_q <= req.shift;
      acc  <= '0;
    end else if (busy) begin
      acc <= (acc << DIG_W) + ACC_W'(part);
      b_q <= b_q << DIG_W;
    end
    if (round) begin
      res <= capped;
    end
  end

endmodule

FILE: rtl/core/force_offset_online_estimator_unit.sv
// Online least-mean-squares estimator of force sensor gains and offset.
//
// The sample channel carries one force sensor word: vertical force and two
// torques. The result channel returns one word per sample with the two
// torque gains, the force offset and the sample count after the update.
// The configuration channel is always ready; index 0 writes the decay
// exponent and index 1 the pause flag. Write it only while the block idles.
//
// The first sample after reset, and any sample while paused, gives its
// result word with no update. In a learning update every product goes through
// one shared multiplier that takes 16 bits of an operand per cycle, and an
// update needs up to 38 products (16 squarings for the logarithm, one scaling,
// up to 16 root products for the power, and five for the correction).
// The block takes no new sample while an update runs. A finished word
// waits in an output register, so a new sample may be taken while the
// receiver stalls; the block then holds its next word until that register
// is free. Reset clears the parameters, the previous sample and the count,
// and restores the default exponent of one half with learning enabled.
module force_offset_online_estimator_unit import foe_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic   clk,
  input  logic   rst,
  foe_sample_if.sink   sample,
  foe_result_if.source result,
  foe_cfg_if.sink      cfg
);

  localparam int GAIN_W = FRAC_BITS + 4;
  localparam int OFS_W  = (DATA_WIDTH > FRAC_BITS + 10) ? DATA_WIDTH : FRAC_BITS + 10;
  localparam logic signed [MAG_W-1:0] GAIN_MAX = MAG_W'(64'sd5 << FRAC_BITS);
  localparam logic signed [MAG_W-1:0] OFS_MIN  = MAG_W'(64'sd100 << FRAC_BITS);
  localparam logic signed [MAG_W-1:0] OFS_MAX  = MAG_W'(64'sd500 << FRAC_BITS);
  localparam logic signed [MAG_W-1:0] REP_MAX  = MAG_W'((64'sd1 << OFS_OUT_W) - 64'sd1);

  state_t state;
  state_t state_next;
  op_t    op;

  logic [ITER_W-1:0]      iter;
  logic [COUNT_W-1:0]     norm_m;
  logic [LOG_INT_W-1:0]   norm_k;
  logic [LOG_INT_W-1:0]   lg_int;
  logic [LOG_FRAC_W-1:0]  lg_frac;
  logic [LOG_W-1:0]       lexp;
  logic [EXP_W-1:0]       pw;
  logic [STEP_W-1:0]      step;
  logic signed [MAG_W-1:0] err;
  logic signed [MAG_W-1:0] delta;

  logic signed [DATA_WIDTH-1:0] in_fz;
  logic signed [DATA_WIDTH-1:0] in_tx;
  logic signed [DATA_WIDTH-1:0] in_ty;
  logic signed [DATA_WIDTH-1:0] last_fz;
  logic signed [DATA_WIDTH-1:0] last_tx;
  logic signed [DATA_WIDTH-1:0] last_ty;
  logic signed [GAIN_W-1:0]     gain_x_q;
  logic signed [GAIN_W-1:0]     gain_y_q;
  logic signed [OFS_W-1:0]      offset_q;
  logic [COUNT_W-1:0]           count;
  logic [COUNT_W-1:0]           count_next;
  logic [RATE_W-1:0]            rate;
  logic                         pause;

  logic                         res_valid;
  logic signed [GAIN_OUT_W-1:0] res_gx;
  logic signed [GAIN_OUT_W-1:0] res_gy;
  logic [OFS_OUT_W-1:0]         res_ofs;
  logic [COUNT_W-1:0]           res_seen;

  mul_req_t         mul_req;
  logic             mul_done;
  logic [MAG_W-1:0] mul_res;
  logic             neg;
  logic signed [MAG_W-1:0] sres;

  logic signed [MAG_W-1:0] tx_ext;
  logic signed [MAG_W-1:0] ty_ext;
  logic signed [MAG_W-1:0] gx_ext;
  logic signed [MAG_W-1:0] gy_ext;
  logic signed [MAG_W-1:0] ofs_ext;
  logic signed [MAG_W-1:0] rep;
  logic                    accept;
  logic                    emit;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic signed [MAG_W-1:0] clamp_s(input logic signed [MAG_W-1:0] v,
                                                       input logic signed [MAG_W-1:0] lo,
                                                       input logic signed [MAG_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  foe_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .res  (mul_res)
  );

  assign tx_ext     = MAG_W'(last_tx);
  assign ty_ext     = MAG_W'(last_ty);
  assign gx_ext     = MAG_W'(gain_x_q);
  assign gy_ext     = MAG_W'(gain_y_q);
  assign ofs_ext    = MAG_W'(offset_q);
  assign rep        = clamp_s(ofs_ext, '0, REP_MAX);
  assign count_next = (&count) ? count : count + 1'b1;
  assign sres       = neg ? -$signed(mul_res) : $signed(mul_res);
  assign accept     = sample.valid && sample.ready;
  assign emit       = (state == ST_DONE) && (!res_valid || result.ready);

  always_comb begin
    mul_req.start = (state == ST_ISSUE);
    mul_req.a     = '0;
    mul_req.b     = '0;
    mul_req.shift = SH_W'(FRAC_BITS);
    neg           = 1'b0;
    case (op)
      OP_SQR: begin
        mul_req.a     = MAG_W'(norm_m);
        mul_req.b     = MAG_W'(norm_m);
        mul_req.shift = SH_W'(31);
      end
      OP_RATE: begin
        mul_req.a     = MAG_W'(rate);
        mul_req.b     = MAG_W'({lg_int, lg_frac});
        mul_req.shift = SH_W'(16);
      end
      OP_EXP: begin
        mul_req.a     = MAG_W'(pw);
        mul_req.b     = MAG_W'(ROOT_ROM[iter[3:0]]);
        mul_req.shift = SH_W'(32);
      end
      OP_ERR_X: begin
        mul_req.a = mag_of(tx_ext);
        mul_req.b = mag_of(gx_ext);
        neg       = tx_ext[MAG_W-1] ^ gx_ext[MAG_W-1];
      end
      OP_ERR_Y: begin
        mul_req.a = mag_of(ty_ext);
        mul_req.b = mag_of(gy_ext);
        neg       = ty_ext[MAG_W-1] ^ gy_ext[MAG_W-1];
      end
      OP_DELTA: begin
        mul_req.a     = mag_of(err);
        mul_req.b     = MAG_W'(step);
        mul_req.shift = SH_W'(16);
        neg           = err[MAG_W-1];
      end
      OP_GAIN_X: begin
        mul_req.a = mag_of(delta);
        mul_req.b = mag_of(tx_ext);
        neg       = delta[MAG_W-1] ^ tx_ext[MAG_W-1];
      end
      OP_GAIN_Y: begin
        mul_req.a = mag_of(delta);
        mul_req.b = mag_of(ty_ext);
        neg       = delta[MAG_W-1] ^ ty_ext[MAG_W-1];
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (count == '0 || pause) ? ST_DONE : ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_m[COUNT_W-1]) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_RATE, OP_EXP: state_next = ST_EXP_SEL;
            OP_GAIN_Y:       state_next = ST_DONE;
            default:         state_next = ST_ISSUE;
          endcase
        end
      end
      ST_EXP_SEL: begin
        if (iter == ITER_W'(ROOT_N)) begin
          state_next = ST_SCALE;
        end else if (lexp[~iter[3:0]]) begin
          state_next = ST_ISSUE;
        end
      end
      ST_SCALE: state_next = ST_ISSUE;
      ST_DONE: begin
        if (!res_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == ST_IDLE);
    cfg.ready    = 1'b1;
  end

  assign result.valid        = res_valid;
  assign result.gain_x       = res_gx;
  assign result.gain_y       = res_gy;
  assign result.force_offset = res_ofs;
  assign result.samples_seen = res_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      rate      <= RATE_W'(32768);
      pause     <= 1'b0;
      count     <= '0;
      gain_x_q  <= '0;
      gain_y_q  <= '0;
      offset_q  <= '0;
      last_fz   <= '0;
      last_tx   <= '0;
      last_ty   <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg_idx_t'(cfg.index))
          CFG_DECAY: rate  <= cfg.data[RATE_W-1:0];
          CFG_PAUSE: pause <= cfg.data[0];
          default:   rate  <= rate;
        endcase
      end
      if (accept && count == '0) begin
        gain_x_q <= '0;
        gain_y_q <= '0;
        offset_q <= OFS_W'(sample.force_z);
      end
      if (state == ST_WAIT && mul_done) begin
        case (op)
          OP_GAIN_X: gain_x_q <= GAIN_W'(clamp_s(gx_ext + sres, -GAIN_MAX, GAIN_MAX));
          OP_GAIN_Y: begin
            gain_y_q <= GAIN_W'(clamp_s(gy_ext + sres, -GAIN_MAX, GAIN_MAX));
            offset_q <= OFS_W'(clamp_s(ofs_ext + delta, OFS_MIN, OFS_MAX));
          end
          default: offset_q <= offset_q;
        endcase
      end
      if (emit) begin
        last_fz   <= in_fz;
        last_tx   <= in_tx;
        last_ty   <= in_ty;
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_fz  <= sample.force_z;
      in_tx  <= sample.torque_x;
      in_ty  <= sample.torque_y;
      norm_m <= count;
      norm_k <= LOG_INT_W'(31);
    end
    case (state)
      ST_NORM: begin
        if (norm_m[COUNT_W-1 -: 8] == 8'h0) begin
          norm_m <= norm_m << 8;
          norm_k <= norm_k - LOG_INT_W'(8);
        end else if (!norm_m[COUNT_W-1]) begin
          norm_m <= norm_m << 1;
          norm_k <= norm_k - 1'b1;
        end else begin
          lg_int  <= norm_k;
          lg_frac <= '0;
          iter    <= '0;
          op      <= OP_SQR;
        end
      end
      ST_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_SQR: begin
              if (mul_res[COUNT_W]) begin
                lg_frac[~iter[3:0]] <= 1'b1;
                norm_m              <= mul_res[COUNT_W:1];
              end else begin
                norm_m <= mul_res[COUNT_W-1:0];
              end
              iter <= iter + 1'b1;
              if (iter == ITER_W'(ROOT_N - 1)) begin
                op <= OP_RATE;
              end
            end
            OP_RATE: begin
              lexp <= mul_res[LOG_W-1:0];
              pw   <= EXP_W'(1) << 32;
              iter <= '0;
            end
            OP_EXP: begin
              pw   <= mul_res[EXP_W-1:0];
              iter <= iter + 1'b1;
            end
            OP_ERR_X: begin
              err <= err - sres;
              op  <= OP_ERR_Y;
            end
            OP_ERR_Y: begin
              err <= err - sres;
              op  <= OP_DELTA;
            end
            OP_DELTA: begin
              delta <= sres;
              op    <= OP_GAIN_X;
            end
            OP_GAIN_X: op <= OP_GAIN_Y;
            default:   op <= op;
          endcase
        end
      end
      ST_EXP_SEL: begin
        if (iter != ITER_W'(ROOT_N)) begin
          if (lexp[~iter[3:0]]) begin
            op <= OP_EXP;
          end else begin
            iter <= iter + 1'b1;
          end
        end
      end
      ST_SCALE: begin
        step <= STEP_W'((pw >> lexp[LOG_W-1:LOG_FRAC_W]) >> 16);
        err  <= MAG_W'(last_fz) - ofs_ext;
        op   <= OP_ERR_X;
      end
      default: begin
        step <= step;
      end
    endcase
    if (emit) begin
      res_gx   <= GAIN_OUT_W'(gx_ext);
      res_gy   <= GAIN_OUT_W'(gy_ext);
      res_ofs  <= OFS_OUT_W'(rep);
      res_seen <= count_next;
    end
  end

endmodule

FILE: rtl/core/foe_checker.sv
// Port-level checks for the force offset estimator, bound to the top level.
module foe_checker import foe_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [GAIN_OUT_W-1:0] gain_x,
  input logic signed [GAIN_OUT_W-1:0] gain_y,
  input logic [COUNT_W-1:0]           samples_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result word dropped before it was taken.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Sample taken while the previous one is still in work.");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> samples_seen != '0)
    else $error("Result word reports no samples seen.");

  a_first_gains: assert property (@(posedge clk) disable iff (rst)
    out_valid && samples_seen == COUNT_W'(1) |-> gain_x == '0 && gain_y == '0)
    else $error("First result word carries nonzero gains.");

endmodule

bind force_offset_online_estimator_unit foe_checker u_foe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .gain_x       (result.gain_x),
  .gain_y       (result.gain_y),
  .samples_seen (result.samples_seen)
);

FILE: tb/foe_tb_pkg.sv
// Sample word type and bit-exact predictor of the force offset estimator.
package foe_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
  } sample_word_t;

  typedef struct packed {
    logic [19:0] gain_x;
    logic [19:0] gain_y;
    logic [24:0] force_offset;
    logic [31:0] samples_seen;
  } estimate_word_t;

  localparam longint CAP = 64'sh1000_0000_0000_0000;

  function automatic longint fixed_mul(longint a, longint b, int unsigned s);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] full;
    logic [127:0] m;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    full = {64'h0, ua} * {64'h0, ub};
    m = (full[127:64] != 0) ? 128'(CAP) : full >> s;
    if (m > 128'(CAP)) m = 128'(CAP);
    return ((a < 0) != (b < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint bound(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'h1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint decay_step(logic [31:0] n, logic [15:0] rate);
    int k;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] lx;
    logic [127:0] p;
    logic [63:0] r;
    k = 31;
    while (k > 0 && n[k] == 1'b0) k--;
    m = {32'h0, n} << (31 - k);
    lg = 64'(k) << 16;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      if (m >= (64'h1 << 32)) begin
        lg[15-i] = 1'b1;
        m = m >> 1;
      end
    end
    lx = ({48'h0, rate} * lg) >> 16;
    p = 128'h1 << 32;
    r = 64'h8000_0000;
    for (int i = 0; i < 16; i++) begin
      if (i > 0) r = int_sqrt(r << 32);
      if (lx[15-i]) p = (p * r) >> 32;
    end
    p = p >> lx[20:16];
    return longint'(p[63:16]);
  endfunction

  class estimator_model;
    logic [15:0] decay;
    bit paused;
    longint prev_fz, prev_tx, prev_ty, gx, gy, ofs;
    logic [31:0] count;

    function void clear();
      decay = 16'h8000;
      paused = 0;
      prev_fz = 0; prev_tx = 0; prev_ty = 0;
      gx = 0; gy = 0; ofs = 0;
      count = 0;
    endfunction

    function estimate_word_t absorb(sample_word_t s);
      estimate_word_t w;
      longint err, delta, stp;
      if (count == 0) begin
        gx = 0; gy = 0; ofs = longint'(s.force_z);
      end else if (!paused) begin
        stp = decay_step(count, decay);
        err = prev_fz - fixed_mul(prev_tx, gx, 16) - fixed_mul(prev_ty, gy, 16) - ofs;
        delta = fixed_mul(err, stp, 16);
        gx = bound(gx + fixed_mul(delta, prev_tx, 16), -(5 <<< 16), 5 <<< 16);
        gy = bound(gy + fixed_mul(delta, prev_ty, 16), -(5 <<< 16), 5 <<< 16);
        ofs = bound(ofs + delta, 100 <<< 16, 500 <<< 16);
      end
      prev_fz = longint'(s.force_z);
      prev_tx = longint'(s.torque_x);
      prev_ty = longint'(s.torque_y);
      if (count != 32'hFFFF_FFFF) count++;
      w.gain_x = gx[19:0];
      w.gain_y = gy[19:0];
      w.force_offset = 25'(bound(ofs, 0, (64'sh1 << 25) - 1));
      w.samples_seen = count;
      return w;
    endfunction
  endclass
endpackage

FILE: tb/tb_top.sv
// Top-level testbench for the force offset estimator.
module tb_top;
  import foe_pkg::*;
  import foe_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  foe_sample_if #(.DATA_WIDTH(32)) sample_ch ();
  foe_result_if result_ch ();
  foe_cfg_if cfg_ch ();

  force_offset_online_estimator_unit dut (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .result(result_ch.source),
    .cfg(cfg_ch.sink)
  );

  estimator_model model = new();
  estimate_word_t pending_words[$];
  int errors = 0;
  int checked = 0;
  int quiet_cycles = 0;
  bit sink_stalls = 1;
  bit src_gaps = 1;

  initial begin
    sample_ch.valid = 0;
    sample_ch.force_z = 0;
    sample_ch.torque_x = 0;
    sample_ch.torque_y = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_DECAY;
    cfg_ch.data = 0;
    result_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
      result_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word, count %0d", result_ch.samples_seen);
        errors++;
      end else begin
        estimate_word_t e;
        e = pending_words.pop_front();
        checked++;
        if (result_ch.gain_x !== e.gain_x) begin
          $error("gain_x: expected %h, got %h", e.gain_x, result_ch.gain_x);
          errors++;
        end
        if (result_ch.gain_y !== e.gain_y) begin
          $error("gain_y: expected %h, got %h", e.gain_y, result_ch.gain_y);
          errors++;
        end
        if (result_ch.force_offset !== e.force_offset) begin
          $error("force_offset: expected %h, got %h", e.force_offset,
                 result_ch.force_offset);
          errors++;
        end
        if (result_ch.samples_seen !== e.samples_seen) begin
          $error("samples_seen: expected %0d, got %0d", e.samples_seen,
                 result_ch.samples_seen);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  // The block is never ready in the cycle after it takes a word, so the
  // extra edge after dropping valid costs no throughput.
  task automatic send_sample(logic [31:0] fz, logic [31:0] tx, logic [31:0] ty);
    sample_word_t s;
    if (src_gaps && $urandom_range(0, 7) == 0) repeat ($urandom_range(1, 8)) @(posedge clk);
    s.force_z = fz;
    s.torque_x = tx;
    s.torque_y = ty;
    sample_ch.valid <= 1'b1;
    sample_ch.force_z <= fz;
    sample_ch.torque_x <= tx;
    sample_ch.torque_y <= ty;
    do @(posedge clk); while (!sample_ch.ready);
    pending_words.push_back(model.absorb(s));
    sample_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_DECAY) model.decay = value;
    else model.paused = value[0];
  endtask

  // Plausible sensor word: force near the offset range, modest torques.
  task automatic send_plausible();
    int fz, tx, ty;
    fz = $urandom_range(50 << 16, 550 << 16);
    tx = $urandom_range(0, 40 << 16) - (20 << 16);
    ty = $urandom_range(0, 40 << 16) - (20 << 16);
    send_sample(fz, tx, ty);
  endtask

  task automatic test_first_and_extremes();
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0, 32'h0, 32'h0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(300 << 16, 1 << 16, -(2 << 16));
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_pause();
    write_reg(CFG_PAUSE, 16'd1);
    repeat (5) send_plausible();
    send_sample(32'hAAAA_5555, 32'h5555_AAAA, 32'h1234_5678);
    write_reg(CFG_PAUSE, 16'd0);
    repeat (3) send_plausible();
  endtask

  task automatic test_exponents();
    write_reg(CFG_DECAY, 16'h0000);
    repeat (4) send_plausible();
    write_reg(CFG_DECAY, 16'hFFFF);
    repeat (4) send_plausible();
    write_reg(CFG_DECAY, 16'h0001);
    repeat (3) send_plausible();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 120 == 119 && i < n - 100) write_reg(CFG_DECAY, 16'($urandom_range(0, 65535)));
      if (i % 200 == 150 && i < n - 100) write_reg(CFG_PAUSE, 16'($urandom_range(0, 1)));
      if (i == n - 100) begin
        write_reg(CFG_PAUSE, 16'd0);
        sink_stalls = 0;
        src_gaps = 0;
      end
      if ($urandom_range(0, 9) < 8) send_plausible();
      else send_sample($urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    model.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_and_extremes();
    test_pause();
    test_exponents();
    test_random(830);
    drain();
    $display("Covered extremes, first sample, pause, decay exponents and random sensor words;");
    $display("%0d result words checked.", checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/foe_pkg.sv
rtl/core/foe_ifs.sv
rtl/core/foe_mul.sv
rtl/core/force_offset_online_estimator_unit.sv
rtl/core/foe_checker.sv
tb/foe_tb_pkg.sv
tb/tb_top.sv
